@@ rtl/core/csra_pkg.sv @@
// csra_pkg: shared field widths, codes and control types for the seat-run allocator
// no dependencies; used by csra_ctrl, csra_datapath, the top level and the checker
package csra_pkg;

	// field and register widths
	localparam int ACT_W      = 2;
	localparam int LEN_W      = 5;
	localparam int IDX_W      = 4;
	localparam int STS_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int SIZE_W     = 5;
	localparam int SCAN_W     = 6;

	// request actions
	localparam logic [ACT_W-1:0] ACT_RESERVE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_OCCUPY  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

	// result status codes
	localparam logic [STS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STS_W-1:0] ST_NO_RUN = 2'd1;
	localparam logic [STS_W-1:0] ST_RANGE  = 2'd2;
	localparam logic [STS_W-1:0] ST_TAKEN  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEATS = 2'd1;

	// what the datapath loads into its pending result
	typedef logic [2:0] pend_sel_t;
	localparam pend_sel_t PEND_NONE   = 3'd0;
	localparam pend_sel_t PEND_ZERO   = 3'd1;
	localparam pend_sel_t PEND_NO_RUN = 3'd2;
	localparam pend_sel_t PEND_RANGE  = 3'd3;
	localparam pend_sel_t PEND_GRANT  = 3'd4;
	localparam pend_sel_t PEND_SINGLE = 3'd5;

	// controller to datapath commands
	typedef struct packed {
		logic      req_load;
		logic      scan_step;
		logic      single_rd;
		pend_sel_t pend_sel;
		logic      out_load;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_reserve;
		logic zero_len;
		logic too_long;
		logic range_bad;
		logic hit;
		logic scan_done;
	} dp_sts_t;

endpackage

@@ rtl/core/csra_ctrl.sv @@
// csra_ctrl: sequencing state machine and output valid register for the allocator
// depends on csra_pkg; drives csra_datapath through ctl_cmd_t
module csra_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  csra_pkg::dp_sts_t  sts,
	output csra_pkg::ctl_cmd_t cmd
);
	import csra_pkg::*;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_DECIDE    = 3'd1;
	localparam logic [2:0] S_SCAN      = 3'd2;
	localparam logic [2:0] S_SINGLE_RD = 3'd3;
	localparam logic [2:0] S_SINGLE_EV = 3'd4;
	localparam logic [2:0] S_FINISH    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.req_load = 1'b1;
					state_d      = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.is_reserve) begin
					priority if (sts.zero_len) begin
						cmd.pend_sel = PEND_ZERO;
						state_d      = S_FINISH;
					end else if (sts.too_long) begin
						cmd.pend_sel = PEND_NO_RUN;
						state_d      = S_FINISH;
					end else begin
						state_d = S_SCAN;
					end
				end else if (sts.range_bad) begin
					cmd.pend_sel = PEND_RANGE;
					state_d      = S_FINISH;
				end else begin
					state_d = S_SINGLE_RD;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				priority if (sts.hit) begin
					cmd.pend_sel = PEND_GRANT;
					state_d      = S_FINISH;
				end else if (sts.scan_done) begin
					cmd.pend_sel = PEND_NO_RUN;
					state_d      = S_FINISH;
				end
			end
			S_SINGLE_RD: begin
				cmd.single_rd = 1'b1;
				state_d       = S_SINGLE_EV;
			end
			S_SINGLE_EV: begin
				cmd.pend_sel = PEND_SINGLE;
				state_d      = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/csra_datapath.sv @@
// csra_datapath: occupancy memory, size registers, run search and result registers
// depends on csra_pkg; commanded by csra_ctrl
module csra_datapath #(
	parameter int MAX_ROWS  = 16,
	parameter int MAX_SEATS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  csra_pkg::ctl_cmd_t                    cmd,
	output csra_pkg::dp_sts_t                     sts,
	input  logic                                  cfg_valid,
	input  logic [csra_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [csra_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic [csra_pkg::ACT_W-1:0]            action,
	input  logic [csra_pkg::LEN_W-1:0]            run_length,
	input  logic [csra_pkg::IDX_W-1:0]            row_index,
	input  logic [csra_pkg::IDX_W-1:0]            seat_index,
	output logic [csra_pkg::STS_W-1:0]            status,
	output logic [csra_pkg::IDX_W-1:0]            granted_row,
	output logic [csra_pkg::IDX_W-1:0]            granted_first_seat
);
	import csra_pkg::*;

	localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int SEAT_AW = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;

	// size registers
	logic [SIZE_W-1:0] rows_q;
	logic [SIZE_W-1:0] seats_q;
	logic [SIZE_W-1:0] nr;
	logic [SIZE_W-1:0] ns;

	// latched request
	logic [ACT_W-1:0] req_act_q;
	logic [LEN_W-1:0] req_len_q;
	logic [IDX_W-1:0] req_row_q;
	logic [IDX_W-1:0] req_seat_q;

	// occupancy memory and per-row valid bits
	logic [MAX_SEATS-1:0] mem [MAX_ROWS];
	logic [MAX_ROWS-1:0]  row_valid_q;

	// scan and read stage
	logic [SCAN_W-1:0]    scan_row_q;
	logic                 scan_more;
	logic                 issue;
	logic [ROW_AW-1:0]    rd_addr;
	logic [MAX_SEATS-1:0] rd_data_s1;
	logic [ROW_AW-1:0]    rd_row_s1;
	logic                 rd_vld_s1;
	logic                 rd_live_s1;
	logic [MAX_SEATS-1:0] rd_word;

	// run search
	logic [MAX_SEATS-1:0] run_mask;
	logic [MAX_SEATS-1:0] cand;
	logic                 found;
	logic [SEAT_AW-1:0]   found_pos;
	logic [MAX_SEATS-1:0] seat_bit;
	logic                 seat_taken;

	// write back
	logic                 wr_en;
	logic [MAX_SEATS-1:0] wr_data;

	// pending and output result
	logic [STS_W-1:0] pend_status_q;
	logic [IDX_W-1:0] pend_row_q;
	logic [IDX_W-1:0] pend_seat_q;
	logic [STS_W-1:0] status_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] seat_q;

	// effective sizes, clamped to the built array
	assign nr = (rows_q < MAX_ROWS) ? rows_q : SIZE_W'(MAX_ROWS);
	assign ns = (seats_q < MAX_SEATS) ? seats_q : SIZE_W'(MAX_SEATS);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= SIZE_W'(9);
			seats_q <= SIZE_W'(10);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROWS:  rows_q  <= cfg_data;
				CFG_SEATS: seats_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_act_q  <= action;
			req_len_q  <= run_length;
			req_row_q  <= row_index;
			req_seat_q <= seat_index;
		end
	end

	// decision flags
	assign sts.is_reserve = (req_act_q == ACT_RESERVE);
	assign sts.zero_len   = (req_len_q == '0);
	assign sts.too_long   = (req_len_q > ns);
	assign sts.range_bad  = (req_act_q == ACT_NONE) ||
		({1'b0, req_row_q} >= ns - ns + nr) || ({1'b0, req_seat_q} >= ns);

	// row scan counter
	assign scan_more = ({1'b0, nr} > scan_row_q);
	assign issue     = (cmd.scan_step && scan_more) || cmd.single_rd;
	assign rd_addr   = cmd.single_rd ? ROW_AW'(req_row_q) : ROW_AW'(scan_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.req_load) begin
				scan_row_q <= '0;
			end else if (cmd.scan_step && scan_more) begin
				scan_row_q <= scan_row_q + SCAN_W'(1);
			end
		end
	end

	// registered memory read
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[rd_addr];
			rd_live_s1 <= row_valid_q[rd_addr];
			rd_row_s1  <= rd_addr;
		end
	end

	// a row never written reads as all free
	assign rd_word = rd_live_s1 ? rd_data_s1 : '0;

	// first-fit search over start positions of one row
	always_comb begin
		found     = 1'b0;
		found_pos = '0;
		for (int i = 0; i < MAX_SEATS; i++) begin
			run_mask[i] = (i < int'(req_len_q));
		end
		for (int s = 0; s < MAX_SEATS; s++) begin
			cand[s] = ((s + int'(req_len_q)) <= int'(ns)) &&
				((rd_word & (run_mask << s)) == '0);
		end
		for (int s = MAX_SEATS - 1; s >= 0; s--) begin
			if (cand[s]) begin
				found     = 1'b1;
				found_pos = SEAT_AW'(s);
			end
		end
	end

	assign sts.hit       = rd_vld_s1 && found;
	assign sts.scan_done = !rd_vld_s1 && !scan_more;

	// single seat lookup
	always_comb begin
		for (int i = 0; i < MAX_SEATS; i++) begin
			seat_bit[i] = (i == int'(req_seat_q));
		end
	end
	assign seat_taken = |(rd_word & seat_bit);

	// write-back data
	always_comb begin
		wr_en   = 1'b0;
		wr_data = rd_word;
		if (cmd.pend_sel == PEND_GRANT) begin
			wr_en   = 1'b1;
			wr_data = rd_word | (run_mask << found_pos);
		end else if (cmd.pend_sel == PEND_SINGLE) begin
			if (req_act_q == ACT_OCCUPY) begin
				wr_en   = !seat_taken;
				wr_data = rd_word | seat_bit;
			end else begin
				wr_en   = 1'b1;
				wr_data = rd_word & ~seat_bit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[rd_row_s1] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[rd_row_s1] <= 1'b1;
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		unique case (cmd.pend_sel)
			PEND_ZERO: begin
				pend_status_q <= ST_OK;
				pend_row_q    <= '0;
				pend_seat_q   <= '0;
			end
			PEND_NO_RUN: begin
				pend_status_q <= ST_NO_RUN;
				pend_row_q    <= '0;
				pend_seat_q   <= '0;
			end
			PEND_RANGE: begin
				pend_status_q <= ST_RANGE;
				pend_row_q    <= req_row_q;
				pend_seat_q   <= req_seat_q;
			end
			PEND_GRANT: begin
				pend_status_q <= ST_OK;
				pend_row_q    <= IDX_W'(rd_row_s1);
				pend_seat_q   <= IDX_W'(found_pos);
			end
			PEND_SINGLE: begin
				pend_status_q <= (req_act_q == ACT_OCCUPY && seat_taken) ? ST_TAKEN : ST_OK;
				pend_row_q    <= req_row_q;
				pend_seat_q   <= req_seat_q;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= pend_status_q;
			row_q    <= pend_row_q;
			seat_q   <= pend_seat_q;
		end
	end

	assign status             = status_q;
	assign granted_row        = row_q;
	assign granted_first_seat = seat_q;

endmodule

@@ rtl/core/contiguous_seat_run_allocator.sv @@
// contiguous_seat_run_allocator: top level, first-fit contiguous seat-run allocator
// depends on csra_pkg, csra_ctrl and csra_datapath
//
//  channel  handshake              payload
//  in       in_valid / in_ready    action, run_length, row_index, seat_index
//  out      out_valid / out_ready  status, granted_row, granted_first_seat
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item at a time; in_ready is high only while the sequencer is idle
// reserve: the memory is read one row per cycle, in row order, until the run is found in
// a row or all min(rows_in_use, MAX_ROWS) rows are read; with no rows in use none is read
// occupy and release read one row and write it back unless the seat is taken; zero count and refused requests read none
// reset clears the map at once through per-row valid bits; no clearing pass
// a stalled out beat holds its result; a new in beat is still taken meanwhile
module contiguous_seat_run_allocator #(
	parameter int MAX_ROWS  = 16,
	parameter int MAX_SEATS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [csra_pkg::ACT_W-1:0]      action,
	input  logic [csra_pkg::LEN_W-1:0]      run_length,
	input  logic [csra_pkg::IDX_W-1:0]      row_index,
	input  logic [csra_pkg::IDX_W-1:0]      seat_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [csra_pkg::STS_W-1:0]      status,
	output logic [csra_pkg::IDX_W-1:0]      granted_row,
	output logic [csra_pkg::IDX_W-1:0]      granted_first_seat,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [csra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csra_pkg::CFG_DATA_W-1:0] cfg_data
);
	import csra_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// size registers are always writable
	assign cfg_ready = 1'b1;

	// sequencer
	csra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// map, search and result registers
	csra_datapath #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_SEATS (MAX_SEATS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_valid          (cfg_valid),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.action             (action),
		.run_length         (run_length),
		.row_index          (row_index),
		.seat_index         (seat_index),
		.status             (status),
		.granted_row        (granted_row),
		.granted_first_seat (granted_first_seat)
	);

endmodule

@@ rtl/core/csra_checker.sv @@
// csra_checker: port-level assertions for the seat-run allocator, bound to the top level
// depends on csra_pkg and contiguous_seat_run_allocator
module csra_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [csra_pkg::STS_W-1:0] status,
	input logic [csra_pkg::IDX_W-1:0] granted_row,
	input logic [csra_pkg::IDX_W-1:0] granted_first_seat
);
	import csra_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(granted_row) && $stable(granted_first_seat))
		else $error("stalled result changed");

	// one item at a time: busy right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an accepted beat");

	// a refused reserve carries no position
	a_no_run_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NO_RUN |-> granted_row == '0 && granted_first_seat == '0)
		else $error("no-run result with nonzero position");

	// a new result appears only as the sequencer returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while busy");

endmodule

bind contiguous_seat_run_allocator csra_checker u_csra_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_ready           (in_ready),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.status             (status),
	.granted_row        (granted_row),
	.granted_first_seat (granted_first_seat)
);

@@ tb/contiguous_seat_run_allocator_tb.sv @@
// contiguous_seat_run_allocator_tb: self-checking bench for the first-fit seat-run allocator
// depends on csra_pkg and contiguous_seat_run_allocator; predicts every result from its own
// copy of the occupancy map and checks each out beat against the oldest prediction
`timescale 1ns / 100ps

module contiguous_seat_run_allocator_tb;
	import csra_pkg::*;

	localparam int MAP_ROWS  = 16;
	localparam int MAP_SEATS = 16;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] seat;
	} seat_grant_t;

	// block ports, every input driven from time zero
	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [ACT_W-1:0]      action     = ACT_RESERVE;
	logic [LEN_W-1:0]      run_length = '0;
	logic [IDX_W-1:0]      row_index  = '0;
	logic [IDX_W-1:0]      seat_index = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic [STS_W-1:0]      status;
	logic [IDX_W-1:0]      granted_row;
	logic [IDX_W-1:0]      granted_first_seat;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = CFG_ROWS;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	// predictor state: occupancy words and the size registers as last written
	logic [31:0]     seat_map [MAP_ROWS];
	logic [SIZE_W-1:0] rows_cfg  = 5'd9;
	logic [SIZE_W-1:0] seats_cfg = 5'd10;
	seat_grant_t     expected_grants [$];

	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int out_hold_req   = 0;
	int out_hold_left  = 0;

	contiguous_seat_run_allocator #(
		.MAX_ROWS (MAP_ROWS),
		.MAX_SEATS(MAP_SEATS)
	) u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.action            (action),
		.run_length        (run_length),
		.row_index         (row_index),
		.seat_index        (seat_index),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.granted_row       (granted_row),
		.granted_first_seat(granted_first_seat),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit, far above the slowest correct run
	initial begin
		#4_000_000;
		$display("contiguous_seat_run_allocator_tb: FAIL");
		$finish;
	end

	function automatic int rows_live();
		return (rows_cfg > MAP_ROWS) ? MAP_ROWS : int'(rows_cfg);
	endfunction

	function automatic int seats_live();
		return (seats_cfg > MAP_SEATS) ? MAP_SEATS : int'(seats_cfg);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// first-fit allocation on the shadow map; queues the grant this request must produce
	task automatic predict_allocation(input logic [ACT_W-1:0] act, input logic [LEN_W-1:0] len,
		input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] seat);
		int          nr;
		int          ns;
		bit          found;
		logic [31:0] run_mask;
		seat_grant_t res;
		nr    = rows_live();
		ns    = seats_live();
		found = 1'b0;
		res   = '{status: ST_OK, row: '0, seat: '0};
		if (act == ACT_RESERVE) begin
			if (len != 0) begin
				res.status = ST_NO_RUN;
				if (len <= ns) begin
					run_mask = (32'd1 << len) - 32'd1;
					for (int r = 0; r < nr && !found; r++)
						for (int s = 0; s + len <= ns && !found; s++)
							if ((seat_map[r] & (run_mask << s)) == 0) begin
								seat_map[r] |= run_mask << s;
								res   = '{status: ST_OK, row: 4'(r), seat: 4'(s)};
								found = 1'b1;
							end
				end
			end
		end else if (act == ACT_NONE || row >= nr || seat >= ns) begin
			res = '{status: ST_RANGE, row: row, seat: seat};
		end else if (act == ACT_OCCUPY) begin
			if (seat_map[row][seat])
				res = '{status: ST_TAKEN, row: row, seat: seat};
			else begin
				seat_map[row][seat] = 1'b1;
				res = '{status: ST_OK, row: row, seat: seat};
			end
		end else begin
			seat_map[row][seat] = 1'b0;
			res = '{status: ST_OK, row: row, seat: seat};
		end
		expected_grants = {expected_grants, res};
	endtask

	// out beat checker, sampled on the rising edge
	always @(posedge clk) begin
		seat_grant_t want;
		if (out_valid && out_ready) begin
			if (expected_grants.size() == 0)
				report_mismatch("beat with nothing pending, status", status, 0);
			else begin
				want = expected_grants.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (granted_row !== want.row)
					report_mismatch("granted_row", granted_row, want.row);
				if (granted_first_seat !== want.seat)
					report_mismatch("granted_first_seat", granted_first_seat, want.seat);
			end
		end
	end

	// receiver: random stalls, or a long counted hold-off on request
	always @(negedge clk) begin
		if (out_hold_left > 0) begin
			out_ready <= 1'b0;
			out_hold_left = out_hold_left - 1;
		end else if (out_hold_req > 0) begin
			out_ready <= 1'b0;
			out_hold_left = out_hold_req - 1;
			out_hold_req  = 0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic set_idle_mode(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
			default: begin send_idle_pct = 31; recv_stall_pct = 31; end
		endcase
	endtask

	// one in beat; prediction happens at the accepting edge
	task automatic send_request(input logic [ACT_W-1:0] act, input logic [LEN_W-1:0] len,
		input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] seat);
		@(negedge clk);
		in_valid   <= 1'b1;
		action     <= act;
		run_length <= len;
		row_index  <= row;
		seat_index <= seat;
		do @(posedge clk); while (!in_ready);
		predict_allocation(act, len, row, seat);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_grants.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_ROWS)
			rows_cfg = val;
		else if (idx == CFG_SEATS)
			seats_cfg = val;
	endtask

	// resize only once the block has gone quiet
	task automatic set_board_size(input int rows, input int seats);
		wait_results_drained();
		write_size_reg(CFG_ROWS, 5'(rows));
		write_size_reg(CFG_SEATS, 5'(seats));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly in-range requests with small runs, some noise across the whole fields
	task automatic send_random_request();
		int               nr;
		int               ns;
		int               pick;
		logic [ACT_W-1:0] act;
		logic [LEN_W-1:0] len;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] seat;
		nr   = rows_live();
		ns   = seats_live();
		pick = $urandom_range(99);
		if (pick < 40)
			act = ACT_RESERVE;
		else if (pick < 62)
			act = ACT_OCCUPY;
		else if (pick < 95)
			act = ACT_RELEASE;
		else
			act = ACT_NONE;
		pick = $urandom_range(9);
		if (pick == 0)
			len = 5'($urandom_range(31));
		else if (pick < 4)
			len = 5'($urandom_range(1, (ns > 1) ? ns : 1));
		else
			len = 5'($urandom_range(1, 3));
		row  = (nr > 0 && $urandom_range(9) != 0) ? 4'($urandom_range(nr - 1))
			: 4'($urandom_range(15));
		seat = (ns > 0 && $urandom_range(9) != 0) ? 4'($urandom_range(ns - 1))
			: 4'($urandom_range(15));
		send_request(act, len, row, seat);
	endtask

	// opening cases on the reset board of 9 rows by 10 seats
	task automatic test_reset_board();
		set_idle_mode(0);
		send_request(ACT_RESERVE, 5'd0, 4'd0, 4'd0);
		send_request(ACT_RESERVE, 5'd10, 4'd0, 4'd0);
		send_request(ACT_RESERVE, 5'd11, 4'd0, 4'd0);
		send_request(ACT_RESERVE, 5'd31, 4'd15, 4'd15);
		send_request(ACT_OCCUPY, 5'd0, 4'd0, 4'd3);
		send_request(ACT_OCCUPY, 5'd0, 4'd8, 4'd9);
		send_request(ACT_OCCUPY, 5'd0, 4'd9, 4'd0);
		send_request(ACT_OCCUPY, 5'd0, 4'd0, 4'd10);
		send_request(ACT_OCCUPY, 5'd0, 4'd15, 4'd15);
		send_request(ACT_RELEASE, 5'd0, 4'd0, 4'd3);
		send_request(ACT_RELEASE, 5'd0, 4'd1, 4'd2);
		send_request(ACT_RELEASE, 5'd0, 4'd9, 4'd9);
		send_request(ACT_NONE, 5'd16, 4'd5, 4'd7);
		send_request(ACT_RESERVE, 5'd1, 4'd0, 4'd0);
		send_request(ACT_RESERVE, 5'd9, 4'd0, 4'd0);
		send_request(ACT_RESERVE, 5'd2, 4'd0, 4'd0);
		send_request(ACT_OCCUPY, 5'd0, 4'd2, 4'd0);
		send_request(ACT_OCCUPY, 5'd0, 4'd2, 4'd2);
		send_request(ACT_RESERVE, 5'd3, 4'd0, 4'd0);
		send_request(ACT_RELEASE, 5'd0, 4'd8, 4'd9);
	endtask

	// clamped, zero and shrunk sizes; hidden bits come back on growth
	task automatic test_size_extremes();
		set_board_size(31, 31);
		send_request(ACT_RESERVE, 5'd16, 4'd0, 4'd0);
		send_request(ACT_OCCUPY, 5'd0, 4'd15, 4'd15);
		send_request(ACT_RESERVE, 5'd16, 4'd0, 4'd0);
		send_request(ACT_RESERVE, 5'd17, 4'd0, 4'd0);
		set_board_size(16, 3);
		send_request(ACT_OCCUPY, 5'd0, 4'd5, 4'd2);
		send_request(ACT_OCCUPY, 5'd0, 4'd5, 4'd3);
		send_request(ACT_RESERVE, 5'd3, 4'd0, 4'd0);
		send_request(ACT_RESERVE, 5'd4, 4'd0, 4'd0);
		set_board_size(16, 16);
		send_request(ACT_RESERVE, 5'd13, 4'd0, 4'd0);
		set_board_size(0, 0);
		send_request(ACT_RESERVE, 5'd1, 4'd0, 4'd0);
		send_request(ACT_RESERVE, 5'd0, 4'd0, 4'd0);
		send_request(ACT_OCCUPY, 5'd0, 4'd0, 4'd0);
		send_request(ACT_RELEASE, 5'd0, 4'd0, 4'd0);
		set_board_size(1, 16);
		repeat (3) send_request(ACT_RESERVE, 5'd16, 4'd0, 4'd0);
	endtask

	// long receiver hold-off while the sender keeps offering, then a full drain and more traffic
	task automatic test_output_backpressure();
		set_board_size(16, 16);
		set_idle_mode(0);
		out_hold_req = 300;
		repeat (8) send_random_request();
		wait_results_drained();
		repeat (20) send_random_request();
	endtask

	// random traffic over a spread of board sizes and idle patterns
	task automatic test_random_traffic();
		int phase_rows  [8] = '{16, 1, 4, 31, 0, 9, 16, 2};
		int phase_seats [8] = '{16, 1, 6, 31, 5, 10, 3, 16};
		for (int p = 0; p < 8; p++) begin
			set_board_size(phase_rows[p], phase_seats[p]);
			set_idle_mode(p % 4);
			repeat (140) send_random_request();
		end
	endtask

	initial begin
		for (int r = 0; r < MAP_ROWS; r++)
			seat_map[r] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_board();
		test_size_extremes();
		test_output_backpressure();
		test_random_traffic();
		wait_results_drained();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && expected_grants.size() == 0)
			$display("contiguous_seat_run_allocator_tb: PASS");
		else
			$display("contiguous_seat_run_allocator_tb: FAIL");
		$finish;
	end

endmodule
